// ===== src/noq_pkg.sv =====
// Package for the note-off timer queue: request and result structs, the per-cell
// entry and control types, mode codes and the state machine type.
// Depends on nothing; every other file refers to it by scoped names.
`timescale 1ns / 1ps

package noq_pkg;

    localparam int unsigned TimeW = 32;
    localparam int unsigned DurW  = 20;
    localparam int unsigned ChW   = 4;
    localparam int unsigned NoteW = 7;
    localparam int unsigned StepW = 16;

    localparam logic [TimeW-1:0] MaxTime = {TimeW{1'b1}};

    typedef enum logic [1:0] {
        MODE_NOTE  = 2'd0,
        MODE_TICK  = 2'd1,
        MODE_START = 2'd2,
        MODE_STOP  = 2'd3
    } t_mode;

    typedef enum logic {
        STATUS_OFF  = 1'b0,
        STATUS_DROP = 1'b1
    } t_status;

    typedef struct packed {
        logic [1:0]       mode;
        logic [TimeW-1:0] event_time;
        logic [DurW-1:0]  duration;
        logic [ChW-1:0]   channel;
        logic [NoteW-1:0] note_number;
        logic [StepW-1:0] time_step;
    } t_in_req;

    typedef struct packed {
        logic [ChW-1:0]   channel_out;
        logic [NoteW-1:0] note_out;
        logic             status;
        logic             last;
    } t_out_req;

    // One stored note-off as held in a cell.
    typedef struct packed {
        logic             valid;
        logic [TimeW-1:0] due;
        logic [ChW-1:0]   channel;
        logic [NoteW-1:0] note;
    } t_entry;

    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_POP    = 2'd2
    } t_cell_op;

    // Control broadcast from the sequencer to every cell.
    typedef struct packed {
        t_cell_op         op;
        logic             flush;
        logic [TimeW-1:0] now;
        logic [TimeW-1:0] new_due;
        logic [ChW-1:0]   new_channel;
        logic [NoteW-1:0] new_note;
    } t_cell_ctl;

    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_INSERT = 2'd1,
        S_DRAIN  = 2'd2
    } t_state;

endpackage

// ===== src/note_off_timer_queue.sv =====
// Top level of the note-off timer queue: sequencer, time keeping, output register
// and the chain of noq_cell slots. Depends on noq_pkg and noq_cell.
`timescale 1ns / 1ps

// The queue keeps up to CAPACITY pending note-offs sorted by due time in a row
// of cells, with equal due times in the order they were scheduled. A schedule
// request is first accepted and its saturated due time worked out; then, in
// the insert state, every cell compares and the row opens a gap in place.
// When the row is full the request instead returns a single dropped result.
// A tick request first advances the clock (only while running) and then, in
// the drain state, releases due offs from the head of the row, one result per
// cycle while the output is not stalled; the final result is known in the
// cycle it is issued. When nothing is due, the drain state finds that out and
// returns to idle. Stop behaves likewise for the whole row. Start only sets the
// running flag. The next request is only taken once the final result has left
// the output register, and the pace is set by the single head-of-row release
// per cycle. New requests are held off while a request is being worked on or a
// result is waiting in the output register.
// There is no clearing pass: reset empties the row at once.

module note_off_timer_queue #(
    parameter int unsigned CAPACITY = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  noq_pkg::t_in_req  i_in_req,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output noq_pkg::t_out_req o_out_req
);

    noq_pkg::t_state   r_state,   n_state;
    logic [noq_pkg::TimeW-1:0] r_time, n_time;
    logic              r_running, n_running;
    logic              r_flush,   n_flush;
    logic [noq_pkg::TimeW-1:0]  r_new_due,  n_new_due;
    logic [noq_pkg::ChW-1:0]    r_new_ch,   n_new_ch;
    logic [noq_pkg::NoteW-1:0]  r_new_note, n_new_note;
    logic              r_out_valid, n_out_valid;
    noq_pkg::t_out_req r_out,     n_out;

    noq_pkg::t_cell_ctl w_ctl;
    noq_pkg::t_entry    w_ent [CAPACITY];
    logic [CAPACITY-1:0] w_ins;
    logic [CAPACITY-1:0] w_rel;

    logic              w_accept;
    logic              w_slot_free;
    logic              w_full;
    logic              w_last;
    logic [noq_pkg::TimeW:0] w_due_sum;
    logic [noq_pkg::TimeW:0] w_time_sum;

    // Requests are taken only when idle with an empty output register.
    assign o_in_stall  = (r_state != noq_pkg::S_IDLE) || r_out_valid;
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_slot_free = !r_out_valid || !i_out_stall;
    assign w_full      = w_ent[CAPACITY-1].valid;

    // The head result is the final one when its successor is not releasable too.
    assign w_last = !w_rel[1];

    // Saturating sums; the carry out of the top bit means overflow.
    assign w_due_sum  = {1'b0, i_in_req.event_time}
                      + {{(noq_pkg::TimeW - noq_pkg::DurW + 1){1'b0}}, i_in_req.duration};
    assign w_time_sum = {1'b0, r_time}
                      + {{(noq_pkg::TimeW - noq_pkg::StepW + 1){1'b0}}, i_in_req.time_step};

    always_comb begin
        n_state     = r_state;
        n_time      = r_time;
        n_running   = r_running;
        n_flush     = r_flush;
        n_new_due   = r_new_due;
        n_new_ch    = r_new_ch;
        n_new_note  = r_new_note;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;

        w_ctl.op          = noq_pkg::OP_HOLD;
        w_ctl.flush       = r_flush;
        w_ctl.now         = r_time;
        w_ctl.new_due     = r_new_due;
        w_ctl.new_channel = r_new_ch;
        w_ctl.new_note    = r_new_note;

        unique case (r_state)
            noq_pkg::S_IDLE: begin
                if (w_accept) begin
                    unique case (noq_pkg::t_mode'(i_in_req.mode))
                        noq_pkg::MODE_NOTE: begin
                            if (w_full) begin
                                n_out_valid       = 1'b1;
                                n_out.channel_out = i_in_req.channel;
                                n_out.note_out    = i_in_req.note_number;
                                n_out.status      = noq_pkg::STATUS_DROP;
                                n_out.last        = 1'b1;
                            end else begin
                                n_new_due  = w_due_sum[noq_pkg::TimeW] ? noq_pkg::MaxTime
                                           : w_due_sum[noq_pkg::TimeW-1:0];
                                n_new_ch   = i_in_req.channel;
                                n_new_note = i_in_req.note_number;
                                n_state    = noq_pkg::S_INSERT;
                            end
                        end
                        noq_pkg::MODE_TICK: begin
                            if (r_running) begin
                                n_time = w_time_sum[noq_pkg::TimeW] ? noq_pkg::MaxTime
                                       : w_time_sum[noq_pkg::TimeW-1:0];
                            end
                            n_flush = 1'b0;
                            n_state = noq_pkg::S_DRAIN;
                        end
                        noq_pkg::MODE_START: begin
                            n_running = 1'b1;
                        end
                        noq_pkg::MODE_STOP: begin
                            n_running = 1'b0;
                            n_flush   = 1'b1;
                            n_state   = noq_pkg::S_DRAIN;
                        end
                        default: begin
                            n_state = noq_pkg::S_IDLE;
                        end
                    endcase
                end
            end
            noq_pkg::S_INSERT: begin
                w_ctl.op = noq_pkg::OP_INSERT;
                n_state  = noq_pkg::S_IDLE;
            end
            noq_pkg::S_DRAIN: begin
                if (!w_rel[0]) begin
                    n_state = noq_pkg::S_IDLE;
                end else if (w_slot_free) begin
                    w_ctl.op          = noq_pkg::OP_POP;
                    n_out_valid       = 1'b1;
                    n_out.channel_out = w_ent[0].channel;
                    n_out.note_out    = w_ent[0].note;
                    n_out.status      = noq_pkg::STATUS_OFF;
                    n_out.last        = w_last;
                    if (w_last) begin
                        n_state = noq_pkg::S_IDLE;
                    end
                end
            end
            default: begin
                n_state = noq_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_new_due  <= n_new_due;
        r_new_ch   <= n_new_ch;
        r_new_note <= n_new_note;
        r_out      <= n_out;
        if (!i_rst_n) begin
            r_state     <= noq_pkg::S_IDLE;
            r_time      <= '0;
            r_running   <= 1'b0;
            r_flush     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_time      <= n_time;
            r_running   <= n_running;
            r_flush     <= n_flush;
            r_out_valid <= n_out_valid;
        end
    end

    // The row of cells: slot 0 is the head, the next off to leave.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic            w_prev_ins;
        noq_pkg::t_entry w_prev_ent;
        noq_pkg::t_entry w_next_ent;

        if (g == 0) begin : g_head
            assign w_prev_ins = 1'b0;
            assign w_prev_ent = '0;
        end else begin : g_body
            assign w_prev_ins = w_ins[g-1];
            assign w_prev_ent = w_ent[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign w_next_ent = '0;
        end else begin : g_inner
            assign w_next_ent = w_ent[g+1];
        end

        noq_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_prev_ins (w_prev_ins),
            .i_prev_ent (w_prev_ent),
            .i_next_ent (w_next_ent),
            .o_ent      (w_ent[g]),
            .o_ins      (w_ins[g]),
            .o_rel      (w_rel[g])
        );
    end

    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out;

endmodule

// ===== src/noq_cell.sv =====
// One slot of the sorted note-off chain: holds an entry and, on command, keeps it,
// takes the inserted off or its left neighbour's entry, or takes its right neighbour's.
// Depends on noq_pkg.
`timescale 1ns / 1ps

module noq_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  noq_pkg::t_cell_ctl i_ctl,
    input  logic               i_prev_ins,
    input  noq_pkg::t_entry    i_prev_ent,
    input  noq_pkg::t_entry    i_next_ent,
    output noq_pkg::t_entry    o_ent,
    output logic               o_ins,
    output logic               o_rel
);

    noq_pkg::t_entry r_ent;
    noq_pkg::t_entry n_ent;

    // The new off lands at or before this slot when this slot is empty or later.
    assign o_ins = !r_ent.valid || (r_ent.due > i_ctl.new_due);
    assign o_rel = r_ent.valid && (i_ctl.flush || (r_ent.due <= i_ctl.now));
    assign o_ent = r_ent;

    always_comb begin
        n_ent = r_ent;
        case (i_ctl.op)
            noq_pkg::OP_INSERT: begin
                if (o_ins) begin
                    if (i_prev_ins) begin
                        n_ent = i_prev_ent;
                    end else begin
                        n_ent.valid   = 1'b1;
                        n_ent.due     = i_ctl.new_due;
                        n_ent.channel = i_ctl.new_channel;
                        n_ent.note    = i_ctl.new_note;
                    end
                end
            end
            noq_pkg::OP_POP: begin
                n_ent = i_next_ent;
            end
            default: begin
                n_ent = r_ent;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_ent.due     <= n_ent.due;
        r_ent.channel <= n_ent.channel;
        r_ent.note    <= n_ent.note;
        if (!i_rst_n) begin
            r_ent.valid <= 1'b0;
        end else begin
            r_ent.valid <= n_ent.valid;
        end
    end

endmodule

// ===== src/noq_checker.sv =====
// Port-level checker for the note-off timer queue and the bind that attaches it.
// Depends on noq_pkg and note_off_timer_queue.
`timescale 1ns / 1ps

module noq_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input noq_pkg::t_in_req  i_in_req,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input noq_pkg::t_out_req o_out_req
);

    // A stalled result stays offered unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_req))
        else $error("stalled result changed");

    // No new request is taken while a result is waiting.
    a_no_accept_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("request accepted with a result pending");

    // A start request produces no result.
    a_start_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_in_req.mode == noq_pkg::MODE_START)
        |=> !o_out_valid)
        else $error("start request produced a result");

    // A dropped note is always the only, and so the final, result of its request.
    a_drop_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_req.status == noq_pkg::STATUS_DROP) |-> o_out_req.last)
        else $error("dropped result without last");

endmodule

bind note_off_timer_queue noq_checker u_noq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_req    (i_in_req),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_req   (o_out_req)
);
